/* src/qte_pkg.sv */
// Package for the quaternion to Euler angle converter: types, constants, CORDIC helpers.
package qte_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 28;
   localparam int CORDIC_STAGES_DEF   = 24;

   // Angle accumulator width: Q.32 radians with headroom for the full table sum
   localparam int ZW = 36;
   localparam int CW = 64;

   localparam logic signed [ZW-1:0] HALF_PI_Q32  = 36'sd6746518852;
   localparam logic signed [ZW-1:0] PI_Q32       = 36'sd13493037705;
   localparam logic        [31:0]   INV_GAIN_Q32 = 32'd2608131496;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } lane_type;

   // Side data riding along the roll/yaw runs
   typedef struct packed {
      logic signed [CW-1:0] ny;
      logic                 degen;
      logic                 yzero;
      logic                 c31zero;
   } side1_type;

   // Side data riding along the pitch run
   typedef struct packed {
      logic signed [ZW-1:0] roll_z;
      logic signed [ZW-1:0] yaw_z;
      logic                 degen;
      logic                 c31zero;
      logic                 ny_neg;
      logic                 pzero;
   } side2_type;

   // Arctangent of 2^-i in Q.32, rounded to nearest
   function automatic logic signed [ZW-1:0] atan_q32(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = 36'sd3373259426;
         5'd1:  r = 36'sd1991351318;
         5'd2:  r = 36'sd1052175346;
         5'd3:  r = 36'sd534100635;
         5'd4:  r = 36'sd268086748;
         5'd5:  r = 36'sd134174063;
         5'd6:  r = 36'sd67103403;
         5'd7:  r = 36'sd33553749;
         5'd8:  r = 36'sd16777131;
         5'd9:  r = 36'sd8388597;
         5'd10: r = 36'sd4194303;
         5'd11: r = 36'sd2097152;
         5'd12: r = 36'sd1048576;
         5'd13: r = 36'sd524288;
         5'd14: r = 36'sd262144;
         5'd15: r = 36'sd131072;
         5'd16: r = 36'sd65536;
         5'd17: r = 36'sd32768;
         5'd18: r = 36'sd16384;
         5'd19: r = 36'sd8192;
         5'd20: r = 36'sd4096;
         5'd21: r = 36'sd2048;
         5'd22: r = 36'sd1024;
         5'd23: r = 36'sd512;
         5'd24: r = 36'sd256;
         5'd25: r = 36'sd128;
         5'd26: r = 36'sd64;
         5'd27: r = 36'sd32;
         5'd28: r = 36'sd16;
         5'd29: r = 36'sd8;
         5'd30: r = 36'sd4;
         5'd31: r = 36'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Quarter turn into the right half plane before vectoring
   function automatic lane_type prerotate(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y);
      lane_type r;
      r.x = x;
      r.y = y;
      r.z = '0;
      if (x[CW-1]) begin
         if (!y[CW-1]) begin
            r.x = y;
            r.y = -x;
            r.z = HALF_PI_Q32;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -HALF_PI_Q32;
         end
      end
      return r;
   endfunction

   // One vectoring micro-rotation, driving y towards zero
   function automatic lane_type cordic_step(input lane_type a, input logic [4:0] i);
      lane_type r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = $signed(a.y) >>> i;
      dy = $signed(a.x) >>> i;
      if (!a.y[CW-1]) begin
         r.x = a.x + dx;
         r.y = a.y - dy;
         r.z = a.z + atan_q32(i);
      end else begin
         r.x = a.x - dx;
         r.y = a.y + dy;
         r.z = a.z - atan_q32(i);
      end
      return r;
   endfunction

endpackage

/* src/quaternion_to_euler_angles.sv */
// Quaternion to roll/pitch/yaw converter: product, DCM, CORDIC and rounding pipeline.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   req     | in        | req_valid, req_ready, req_q_scalar/_x/_y/_z (Q1.30)
//   rsp     | out       | rsp_valid, rsp_ready, rsp_roll/_yaw (Q3.28),
//           |           | rsp_pitch (Q2.28), rsp_pitch_degenerate
//
// It accepts one quaternion per cycle while results are taken. The pipeline is
// made of two chained CORDIC vectoring runs (roll/yaw, then pitch) of one register
// stage per micro-rotation, plus product, DCM, pre-rotation, gain correction
// (partial products, then sum) and output rounding stages.
// The whole pipeline advances together; it holds while a result waits untaken.
// Reset clears the valid bits only.
module quaternion_to_euler_angles #(
   parameter int ANGLE_FRAC_BITS = qte_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_q_scalar,
   input  logic signed [31:0]                req_q_x,
   input  logic signed [31:0]                req_q_y,
   input  logic signed [31:0]                req_q_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ANGLE_FRAC_BITS+2:0] rsp_roll,
   output logic signed [ANGLE_FRAC_BITS+1:0] rsp_pitch,
   output logic signed [ANGLE_FRAC_BITS+2:0] rsp_yaw,
   output logic                              rsp_pitch_degenerate
);
   import qte_pkg::*;

   localparam int N     = CORDIC_STAGES;
   localparam int SH    = 32 - ANGLE_FRAC_BITS;
   localparam int NV    = 2 * N + 5;
   localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
   localparam logic signed [ZW-1:0] PI_LIM = (PI_Q32 + HALF) >>> SH;
   localparam logic signed [ZW-1:0] HP_LIM = (HALF_PI_Q32 + HALF) >>> SH;

   logic en;
   logic [NV-1:0] v_ff;
   logic [NV-1:0] v_in;
   logic          rsp_valid_ff;

   // Whole pipe moves unless the output holds an untaken result
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;

   assign v_in = {v_ff[NV-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= v_in;
         rsp_valid_ff <= v_ff[NV-1];
      end
   end

   // Stage 1: the ten component products, scaled down by four bits
   logic signed [63:0] full_in [10];
   logic signed [59:0] p_ff    [10];

   always_comb begin
      full_in[0] = req_q_scalar * req_q_scalar;
      full_in[1] = req_q_x * req_q_x;
      full_in[2] = req_q_y * req_q_y;
      full_in[3] = req_q_z * req_q_z;
      full_in[4] = req_q_x * req_q_y;
      full_in[5] = req_q_scalar * req_q_z;
      full_in[6] = req_q_x * req_q_z;
      full_in[7] = req_q_scalar * req_q_y;
      full_in[8] = req_q_y * req_q_z;
      full_in[9] = req_q_scalar * req_q_x;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 10; i++) begin
            p_ff[i] <= full_in[i][63:4];
         end
      end
   end

   // Stage 2: direction-cosine terms
   logic signed [CW-1:0] c11_ff, c21_ff, c31_ff, c32_ff, c33_ff;
   logic signed [CW-1:0] pe [10];

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         pe[i] = CW'(p_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c11_ff <= pe[0] + pe[1] - pe[2] - pe[3];
         c21_ff <= (pe[4] + pe[5]) <<< 1;
         c31_ff <= (pe[6] - pe[7]) <<< 1;
         c32_ff <= (pe[8] + pe[9]) <<< 1;
         c33_ff <= pe[0] - pe[1] - pe[2] + pe[3];
      end
   end

   // Stage 3 and the roll/yaw runs
   lane_type  roll_ff [N+1];
   lane_type  yaw_ff  [N+1];
   side1_type s1_ff   [N+1];
   side1_type s1_in;

   always_comb begin
      s1_in.ny      = -c31_ff;
      s1_in.degen   = (c32_ff == '0) && (c33_ff == '0);
      s1_in.yzero   = (c21_ff == '0) && (c11_ff == '0);
      s1_in.c31zero = (c31_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff[0] <= prerotate(c33_ff, c32_ff);
         yaw_ff[0]  <= prerotate(c11_ff, c21_ff);
         s1_ff[0]   <= s1_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_ry
      always_ff @(posedge clock) begin
         if (en) begin
            roll_ff[k+1] <= cordic_step(roll_ff[k], 5'(k));
            yaw_ff[k+1]  <= cordic_step(yaw_ff[k], 5'(k));
            s1_ff[k+1]   <= s1_ff[k];
         end
      end
   end

   // Gain correction, first step: two partial products of the magnitude
   logic [63:0]          phi_ff, plo_ff;
   logic signed [CW-1:0] ny_ff;
   side2_type            sm_ff;
   side2_type            sm_in;

   always_comb begin
      sm_in.roll_z  = s1_ff[N].degen ? '0 : roll_ff[N].z;
      sm_in.yaw_z   = s1_ff[N].yzero ? '0 : yaw_ff[N].z;
      sm_in.degen   = s1_ff[N].degen;
      sm_in.c31zero = s1_ff[N].c31zero;
      sm_in.ny_neg  = s1_ff[N].ny[CW-1];
      sm_in.pzero   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff <= roll_ff[N].x[63:32] * INV_GAIN_Q32;
         plo_ff <= roll_ff[N].x[31:0] * INV_GAIN_Q32;
         ny_ff  <= s1_ff[N].ny;
         sm_ff  <= sm_in;
      end
   end

   // Gain correction, second step: sum, then the pitch run
   lane_type  pitch_ff [N+1];
   side2_type s2_ff    [N+1];
   logic [63:0] m_sum;
   side2_type   s2_in;

   always_comb begin
      m_sum       = phi_ff + (plo_ff >> 32);
      s2_in       = sm_ff;
      s2_in.pzero = (m_sum == '0) && (ny_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_ff[0].x <= $signed(m_sum);
         pitch_ff[0].y <= ny_ff;
         pitch_ff[0].z <= '0;
         s2_ff[0]      <= s2_in;
      end
   end

   for (genvar k = 0; k < N; k++) begin : g_p
      always_ff @(posedge clock) begin
         if (en) begin
            pitch_ff[k+1] <= cordic_step(pitch_ff[k], 5'(k));
            s2_ff[k+1]    <= s2_ff[k];
         end
      end
   end

   // Output: degenerate pitch select, round half up, clamp
   side2_type            sf;
   logic signed [ZW-1:0] pz, rr, pr, yr;
   logic signed [ANGLE_FRAC_BITS+2:0] rsp_roll_ff, rsp_yaw_ff;
   logic signed [ANGLE_FRAC_BITS+1:0] rsp_pitch_ff;
   logic                              rsp_degen_ff;

   always_comb begin
      sf = s2_ff[N];
      if (sf.degen) begin
         if (sf.c31zero) begin
            pz = '0;
         end else begin
            pz = sf.ny_neg ? -HALF_PI_Q32 : HALF_PI_Q32;
         end
      end else begin
         pz = sf.pzero ? '0 : pitch_ff[N].z;
      end
      rr = (sf.roll_z + HALF) >>> SH;
      yr = (sf.yaw_z + HALF) >>> SH;
      pr = (pz + HALF) >>> SH;
      if (rr > PI_LIM) rr = PI_LIM;
      if (rr < -PI_LIM) rr = -PI_LIM;
      if (yr > PI_LIM) yr = PI_LIM;
      if (yr < -PI_LIM) yr = -PI_LIM;
      if (pr > HP_LIM) pr = HP_LIM;
      if (pr < -HP_LIM) pr = -HP_LIM;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_roll_ff  <= rr[ANGLE_FRAC_BITS+2:0];
         rsp_yaw_ff   <= yr[ANGLE_FRAC_BITS+2:0];
         rsp_pitch_ff <= pr[ANGLE_FRAC_BITS+1:0];
         rsp_degen_ff <= sf.degen;
      end
   end

   assign rsp_roll             = rsp_roll_ff;
   assign rsp_yaw              = rsp_yaw_ff;
   assign rsp_pitch            = rsp_pitch_ff;
   assign rsp_pitch_degenerate = rsp_degen_ff;

`ifndef ASSERT_OFF
   // A degenerate roll vector always yields zero roll
   a_degen_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch_degenerate |-> rsp_roll == '0)
      else $error("roll not zero on degenerate pitch");

   // Pitch stays inside plus or minus a quarter turn
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ZW'(rsp_pitch) <= HP_LIM) && (ZW'(rsp_pitch) >= -HP_LIM))
      else $error("pitch out of range");

   // A held pipeline keeps every valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff) && rsp_valid)
      else $error("pipeline moved while held");
`endif

endmodule
